>>> rtl/core/fmrq_pkg.sv
// Package for the first-match rate quota block.
// Holds the beat structs, function codes and state encodings; no dependencies.
package fmrq_pkg;

   localparam logic [14:0] WAIT_CAP = 15'd32000;
   localparam logic [31:0] PERCENT_MAX = 32'd100;

   typedef enum logic [1:0] {
      FUNC_WRITE  = 2'd0,
      FUNC_CLEAR  = 2'd1,
      FUNC_UPDATE = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LIMIT,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [1:0]  chain_select;
      logic [2:0]  slot;
      logic [31:0] base_addr;
      logic [31:0] addr_mask;
      logic        limit_mode;
      logic [31:0] limit_amount;
      logic        slot_enable;
      logic [31:0] peer_addr;
      logic [31:0] byte_delta;
      logic [31:0] elapsed_msec;
   } req_type;

   typedef struct packed {
      logic [14:0] wait_msec;
      logic        matched;
      logic        accepted;
   } rsp_type;

   // Command broadcast to every cell.
   typedef struct packed {
      logic        write;
      logic        clear;
      logic        add;
      logic [31:0] base;
      logic [31:0] mask;
      logic        mode;
      logic [31:0] limit;
      logic        enable;
      logic [63:0] delta;
   } cell_cmd_type;

   // Token passed from cell to cell during a search.
   typedef struct packed {
      logic        found;
      logic        mode;
      logic [31:0] limit;
      logic [63:0] bytes;
   } cell_tok_type;

endpackage

>>> rtl/core/fmrq_cell.sv
// One rule slot of a chain: holds the rule and its byte accumulator.
// Depends on fmrq_pkg.
module fmrq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  fmrq_pkg::cell_cmd_type cmd,
   input  logic                  sel,
   input  logic                  scan,
   input  logic [31:0]           peer,
   input  fmrq_pkg::cell_tok_type tok_in,
   output fmrq_pkg::cell_tok_type tok_out
);
   import fmrq_pkg::*;

   logic        active_ff;
   logic [31:0] base_ff;
   logic [31:0] mask_ff;
   logic        mode_ff;
   logic [31:0] limit_ff;
   logic [63:0] bytes_ff;
   logic        hit;
   logic [63:0] bytes_in;

   assign hit = scan && !tok_in.found && active_ff && (((peer & mask_ff) & base_ff) == base_ff);
   assign bytes_in = bytes_ff + cmd.delta;

   always_comb begin
      tok_out = tok_in;
      if (hit) begin
         tok_out.found = 1'b1;
         tok_out.mode  = mode_ff;
         tok_out.limit = limit_ff;
         tok_out.bytes = bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (sel && cmd.write) begin
         active_ff <= cmd.enable;
      end else if (sel && cmd.clear) begin
         active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_ff <= '0;
      end else if (sel && cmd.write && cmd.enable) begin
         bytes_ff <= '0;
      end else if (hit && cmd.add) begin
         bytes_ff <= bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sel && cmd.write && cmd.enable) begin
         base_ff  <= cmd.base;
         mask_ff  <= cmd.mask;
         mode_ff  <= cmd.mode;
         limit_ff <= cmd.limit;
      end
   end

endmodule

>>> rtl/core/fmrq_div.sv
// Restoring divider, one quotient bit per cycle, 64 by 64 bits.
// Depends on nothing else.
module fmrq_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient,
   output logic [63:0] remainder
);
   logic [63:0] q_ff, q_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] d_ff;
   logic [6:0]  cnt_ff;
   logic        busy_ff;
   logic [64:0] trial;

   always_comb begin
      trial = {r_ff, q_ff[63]} - {1'b0, d_ff};
      if (!trial[64]) begin
         r_in = trial[63:0];
         q_in = {q_ff[62:0], 1'b1};
      end else begin
         r_in = {r_ff[62:0], q_ff[63]};
         q_in = {q_ff[62:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done    <= 1'b0;
      end else begin
         done <= 1'b0;
         if (go) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 7'd64;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 7'd1;
            if (cnt_ff == 7'd1) begin
               busy_ff <= 1'b0;
               done    <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         q_ff <= dividend;
         r_ff <= '0;
         d_ff <= divisor;
      end else if (busy_ff) begin
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign quotient  = q_ff;
   assign remainder = r_ff;

endmodule

>>> rtl/core/first_match_rate_quota.sv
// First-match rate quota block: a row of rule cells for each chain, a shared
// serial divider and a sequencer.
// Each command takes one beat and returns one beat on the rsp strobe. A write, a clear,
// an unused code or an update without a match passes through the scan and done states
// before its result is strobed, and busy drops in the cycle after the strobe; a matching
// update also passes through the limit state. An update over a nonzero quota with nonzero
// elapsed time runs the serial divider once or twice (excess/limit, then
// remainder*elapsed/limit) before its result comes. Busy is high meanwhile. Results
// cannot be stalled.
module first_match_rate_quota #(
   parameter int CHAINS = 3,
   parameter int RULES  = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  fmrq_pkg::req_type req_data,
   output logic              rsp_valid,
   output fmrq_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [0:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import fmrq_pkg::*;

   localparam int CW = (CHAINS > 1) ? $clog2(CHAINS) : 1;

   state_type   state_ff, state_in;
   req_type     req_ff;
   logic [31:0] bw_ff;
   cell_cmd_type cmd;
   logic        scan;
   cell_tok_type tok [CHAINS][RULES+1];
   cell_tok_type hit_ff;
   logic [63:0] lim_ff;
   logic        phase_ff;
   logic [63:0] q1_ff;
   logic        div_go;
   logic [63:0] div_num;
   logic        div_done;
   logic [63:0] div_q, div_r;
   logic        out_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        chain_ok;
   logic [CW-1:0] chain_idx;
   logic        slot_ok;
   logic [63:0] prod;
   logic [31:0] bw_div_ff;
   logic [63:0] bw_recip;
   logic [63:0] lim_now;

   assign pready = 1'b1;
   assign prdata = bw_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff <= '0;
      end else if (psel && penable && pwrite && paddr == 1'b0) begin
         bw_ff <= pwdata;
      end
   end

   // Bandwidth divided by 100 through a reciprocal multiplication.
   assign bw_recip = 64'(bw_ff) * 64'(32'h51EB_851F);
   always_ff @(posedge clock) begin
      if (reset) begin
         bw_div_ff <= '0;
      end else begin
         bw_div_ff <= {5'd0, bw_recip[63:37]};
      end
   end

   assign chain_ok  = {30'd0, req_ff.chain_select} < CHAINS;
   assign chain_idx = req_ff.chain_select[CW-1:0];
   assign slot_ok   = {29'd0, req_ff.slot} < RULES;

   always_comb begin
      cmd.write  = (state_ff == ST_SCAN) && req_ff.func == FUNC_WRITE && slot_ok &&
                   !(req_ff.slot_enable && req_ff.limit_mode &&
                     req_ff.limit_amount > PERCENT_MAX);
      cmd.clear  = (state_ff == ST_SCAN) && req_ff.func == FUNC_CLEAR;
      cmd.add    = (state_ff == ST_SCAN) && req_ff.func == FUNC_UPDATE;
      cmd.base   = req_ff.base_addr;
      cmd.mask   = req_ff.addr_mask;
      cmd.mode   = req_ff.limit_mode;
      cmd.limit  = req_ff.limit_amount;
      cmd.enable = req_ff.slot_enable;
      cmd.delta  = {{32{req_ff.byte_delta[31]}}, req_ff.byte_delta};
   end
   assign scan = cmd.add;

   for (genvar c = 0; c < CHAINS; c++) begin : g_chain
      assign tok[c][0] = '0;
      for (genvar s = 0; s < RULES; s++) begin : g_cell
         fmrq_cell u_cell (
            .clock  (clock),
            .reset  (reset),
            .cmd    (cmd),
            .sel    (chain_ok && chain_idx == CW'(c) &&
                     (cmd.clear || req_ff.slot == 3'(s))),
            .scan   (scan && chain_ok && chain_idx == CW'(c)),
            .peer   (req_ff.peer_addr),
            .tok_in (tok[c][s]),
            .tok_out(tok[c][s+1])
         );
      end
   end

   assign prod    = hit_ff.mode ? (64'(bw_div_ff) * 64'(hit_ff.limit)) : 64'(hit_ff.limit);
   assign lim_now = (state_ff == ST_LIMIT) ? prod : lim_ff;
   assign div_num = (state_ff == ST_DIV) ?
                    (64'(div_r[31:0]) * 64'(req_ff.elapsed_msec)) : (hit_ff.bytes - lim_now);

   fmrq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_num),
      .divisor  (lim_now),
      .done     (div_done),
      .quotient (div_q),
      .remainder(div_r)
   );

   always_comb begin
      logic [63:0] w;
      w        = '0;
      state_in = state_ff;
      div_go   = 1'b0;
      rsp_in   = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && !out_ff) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            rsp_in.wait_msec = '0;
            rsp_in.matched   = 1'b0;
            rsp_in.accepted  = chain_ok && (cmd.write || cmd.clear ||
                               (req_ff.func == FUNC_WRITE && slot_ok && !req_ff.slot_enable));
            state_in = ST_DONE;
            if (scan && chain_ok && tok[chain_idx][RULES].found) begin
               rsp_in.matched = 1'b1;
               state_in = ST_LIMIT;
            end
         end
         ST_LIMIT: begin
            if ((hit_ff.bytes ^ 64'h8000_0000_0000_0000) <=
                (lim_now ^ 64'h8000_0000_0000_0000)) begin
               state_in = ST_DONE;
            end else if (lim_now == '0) begin
               rsp_in.wait_msec = WAIT_CAP;
               state_in = ST_DONE;
            end else if (req_ff.elapsed_msec == '0) begin
               state_in = ST_DONE;
            end else begin
               div_go   = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               if (!phase_ff) begin
                  if (div_q >= 64'(WAIT_CAP)) begin
                     rsp_in.wait_msec = WAIT_CAP;
                     state_in = ST_DONE;
                  end else begin
                     div_go = 1'b1;
                  end
               end else begin
                  w = q1_ff + div_q;
                  rsp_in.wait_msec = (w >= 64'(WAIT_CAP)) ? WAIT_CAP : w[14:0];
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_ff   <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_ff   <= (state_ff == ST_DONE);
         if (state_ff == ST_LIMIT) phase_ff <= 1'b0;
         else if (state_ff == ST_DIV && div_done && !phase_ff) phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (state_ff == ST_IDLE && start && !out_ff) req_ff <= req_data;
      if (state_ff == ST_SCAN) hit_ff <= tok[chain_idx][RULES];
      if (state_ff == ST_LIMIT) lim_ff <= prod;
      if (state_ff == ST_DIV && div_done && !phase_ff)
         q1_ff <= {17'd0, 47'(div_q[14:0]) * 47'(req_ff.elapsed_msec)};
   end

   assign busy      = (state_ff != ST_IDLE) || out_ff;
   assign rsp_valid = out_ff;
   assign rsp_data  = rsp_ff;

   // The divider runs only while the sequencer waits on it.
   assert property (@(posedge clock) disable iff (reset)
      div_go |=> state_ff == ST_DIV) else $error("divider started outside a division");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == ST_DONE) else $error("response without completion");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.matched && rsp_data.accepted)) else $error("bad flags");

endmodule

>>> tb/tb_first_match_rate_quota.sv
// Self-checking testbench for first_match_rate_quota: directed and random command beats,
// checked against a built-in predictor of the rule chains and quota arithmetic.
// Depends on fmrq_pkg and the first_match_rate_quota RTL.
module tb_first_match_rate_quota;
   import fmrq_pkg::*;

   localparam int NCH = 3;
   localparam int NRU = 8;
   localparam int WATCH_LIMIT = 20000;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   req_type req_data;
   logic rsp_valid;
   rsp_type rsp_data;
   logic psel, penable, pwrite;
   logic [0:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   first_match_rate_quota #(.CHAINS(NCH), .RULES(NRU)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Predictor state.
   logic [31:0] bw_model;
   logic        act_m [NCH*NRU];
   logic [31:0] base_m [NCH*NRU];
   logic [31:0] mask_m [NCH*NRU];
   logic        mode_m [NCH*NRU];
   logic [31:0] lim_m [NCH*NRU];
   logic [63:0] acc_m [NCH*NRU];

   req_type cmd_queue[$];
   rsp_type quota_expect[$];
   int errors;
   int gap_left;
   bit gaps_on;
   int idle_cycles;
   logic [31:0] csr_wr_data;
   bit csr_wr_req;
   bit csr_wr_done;

   function automatic logic [14:0] quota_wait(logic [63:0] acc, logic [63:0] lim,
                                              logic [63:0] elapsed);
      logic [63:0] excess, q, r;
      logic [127:0] w;
      if ($signed(acc) <= $signed(lim)) return 15'd0;
      if (lim == 0) return WAIT_CAP;
      excess = acc - lim;
      q = excess / lim;
      r = excess % lim;
      if (elapsed == 0) return 15'd0;
      if (q >= 32000) return WAIT_CAP;
      w = 128'(q) * elapsed + (128'(r) * elapsed) / lim;
      return (w >= 32000) ? WAIT_CAP : w[14:0];
   endfunction

   function automatic rsp_type predict_quota(req_type c);
      rsp_type o;
      int k;
      logic [63:0] lim;
      o = '0;
      if (c.chain_select < NCH) begin
         if (c.func == FUNC_WRITE) begin
            k = c.chain_select * NRU + c.slot;
            if (!c.slot_enable) begin
               act_m[k] = 1'b0;
               o.accepted = 1'b1;
            end else if (!(c.limit_mode && c.limit_amount > PERCENT_MAX)) begin
               act_m[k] = 1'b1;
               base_m[k] = c.base_addr;
               mask_m[k] = c.addr_mask;
               mode_m[k] = c.limit_mode;
               lim_m[k] = c.limit_amount;
               acc_m[k] = '0;
               o.accepted = 1'b1;
            end
         end else if (c.func == FUNC_CLEAR) begin
            for (int s = 0; s < NRU; s++) act_m[c.chain_select * NRU + s] = 1'b0;
            o.accepted = 1'b1;
         end else if (c.func == FUNC_UPDATE) begin
            for (int s = 0; s < NRU; s++) begin
               k = c.chain_select * NRU + s;
               if (act_m[k] && ((c.peer_addr & mask_m[k]) & base_m[k]) == base_m[k]) begin
                  o.matched = 1'b1;
                  acc_m[k] = acc_m[k] + {{32{c.byte_delta[31]}}, c.byte_delta};
                  lim = mode_m[k] ? 64'(bw_model / PERCENT_MAX) * 64'(lim_m[k])
                                  : 64'(lim_m[k]);
                  o.wait_msec = quota_wait(acc_m[k], lim, 64'(c.elapsed_msec));
                  break;
               end
            end
         end
      end
      return o;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Command driver.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_data <= '0;
         gap_left <= 0;
      end else if (!(start && busy)) begin
         if (start) begin
            quota_expect.push_back(predict_quota(req_data));
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start <= 1'b0;
         end else if (cmd_queue.size() > 0 && !csr_wr_req) begin
            if (gaps_on && $urandom_range(0, 9) == 0) begin
               gap_left <= $urandom_range(0, 10);
               start <= 1'b0;
            end else begin
               req_data <= cmd_queue.pop_front();
               start <= 1'b1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (quota_expect.size() == 0) begin
            $display("%0t: unexpected beat, actual %p", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = quota_expect.pop_front();
            if (e.wait_msec !== rsp_data.wait_msec) begin
               $display("%0t: wait_msec expected %0d actual %0d", $time, e.wait_msec,
                        rsp_data.wait_msec);
               errors++;
            end
            if (e.matched !== rsp_data.matched) begin
               $display("%0t: matched expected %0b actual %0b", $time, e.matched,
                        rsp_data.matched);
               errors++;
            end
            if (e.accepted !== rsp_data.accepted) begin
               $display("%0t: accepted expected %0b actual %0b", $time, e.accepted,
                        rsp_data.accepted);
               errors++;
            end
         end
      end
   end

   // Register write port and watchdog.
   always @(posedge clock) begin
      if (reset) begin
         psel <= 1'b0;
         penable <= 1'b0;
         pwrite <= 1'b0;
         paddr <= '0;
         pwdata <= '0;
         csr_wr_done <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (psel && penable) begin
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            bw_model <= csr_wr_data;
            csr_wr_done <= 1'b1;
         end else if (psel) begin
            penable <= 1'b1;
         end else if (csr_wr_req && !csr_wr_done) begin
            psel <= 1'b1;
            pwrite <= 1'b1;
            paddr <= '0;
            pwdata <= csr_wr_data;
         end else if (!csr_wr_req) begin
            csr_wr_done <= 1'b0;
         end
         if ((start && !busy) || rsp_valid || psel) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic req_type rand_cmd(int pct_update);
      req_type c;
      c = '0;
      c.func = ($urandom_range(0, 99) < pct_update) ? FUNC_UPDATE
               : (($urandom_range(0, 19) == 0) ? FUNC_NONE
               : (($urandom_range(0, 9) == 0) ? FUNC_CLEAR : FUNC_WRITE));
      c.chain_select = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      c.slot = 3'($urandom);
      c.base_addr = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom & 32'hff00_0000);
      c.addr_mask = ($urandom_range(0, 1) == 0) ? $urandom : 32'hffff_0000;
      c.limit_mode = 1'($urandom);
      c.limit_amount = ($urandom_range(0, 4) == 0) ? $urandom
                       : $urandom_range(0, c.limit_mode ? 120 : 5000);
      c.slot_enable = ($urandom_range(0, 7) != 0);
      c.peer_addr = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom | 32'h00ff_ffff);
      c.byte_delta = ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 3000));
      c.elapsed_msec = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 2000);
      return c;
   endfunction

   task automatic wait_drained();
      while (cmd_queue.size() > 0 || start || quota_expect.size() > 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic set_bandwidth(logic [31:0] value);
      csr_wr_data = value;
      csr_wr_req = 1'b1;
      while (!csr_wr_done) @(posedge clock);
      csr_wr_req = 1'b0;
      @(posedge clock);
   endtask

   initial begin
      req_type c;
      logic [31:0] bw_set [4];
      errors = 0;
      gaps_on = 1'b0;
      csr_wr_req = 1'b0;
      csr_wr_data = '0;
      bw_model = '0;
      for (int i = 0; i < NCH*NRU; i++) begin
         act_m[i] = 1'b0; base_m[i] = '0; mask_m[i] = '0; mode_m[i] = 1'b0; lim_m[i] = '0;
         acc_m[i] = '0;
      end
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_bandwidth(32'd10000);

      // Directed beats: writes of every kind, updates over and under quota.
      c = '0; c.func = FUNC_WRITE; c.slot = 3'd0; c.base_addr = 32'h0a00_0000;
      c.addr_mask = 32'hff00_0000; c.limit_amount = 32'd1000; c.slot_enable = 1'b1;
      cmd_queue.push_back(c);
      c.slot = 3'd7; c.base_addr = 32'h0; c.addr_mask = 32'h0; c.limit_mode = 1'b1;
      c.limit_amount = 32'd100; cmd_queue.push_back(c);
      c.limit_amount = 32'd101; cmd_queue.push_back(c);
      c.limit_amount = 32'hffff_ffff; cmd_queue.push_back(c);
      c = '0; c.func = FUNC_WRITE; c.chain_select = 2'd1; c.slot = 3'd2;
      c.base_addr = 32'hffff_ffff; c.addr_mask = 32'hffff_ffff; c.limit_amount = 32'd0;
      c.slot_enable = 1'b1; cmd_queue.push_back(c);
      c = '0; c.func = FUNC_UPDATE; c.peer_addr = 32'h0a01_0203; c.byte_delta = 32'd500;
      c.elapsed_msec = 32'd10; cmd_queue.push_back(c);
      c.byte_delta = 32'd2000; cmd_queue.push_back(c);
      c.elapsed_msec = 32'd0; cmd_queue.push_back(c);
      c.elapsed_msec = 32'hffff_ffff; c.byte_delta = 32'h7fff_ffff; cmd_queue.push_back(c);
      c.byte_delta = 32'h8000_0000; cmd_queue.push_back(c);
      c.peer_addr = 32'h0b00_0000; c.byte_delta = 32'd5; cmd_queue.push_back(c);
      c.chain_select = 2'd1; c.peer_addr = 32'hffff_ffff; c.byte_delta = 32'd1;
      cmd_queue.push_back(c);
      c.peer_addr = 32'hfffe_ffff; cmd_queue.push_back(c);
      c.chain_select = 2'd3; cmd_queue.push_back(c);
      c = '0; c.func = FUNC_NONE; c.chain_select = 2'd0; cmd_queue.push_back(c);
      c = '0; c.func = FUNC_WRITE; c.slot = 3'd0; c.slot_enable = 1'b0;
      c.limit_mode = 1'b1; c.limit_amount = 32'd500; cmd_queue.push_back(c);
      c = '0; c.func = FUNC_CLEAR; c.chain_select = 2'd1; cmd_queue.push_back(c);
      c.chain_select = 2'd3; cmd_queue.push_back(c);
      c = '0; c.func = FUNC_UPDATE; c.peer_addr = 32'hffff_ffff; c.byte_delta = 32'hffff_ffff;
      c.elapsed_msec = 32'd7; cmd_queue.push_back(c);
      wait_drained();

      bw_set[0] = 32'd0; bw_set[1] = 32'hffff_ffff; bw_set[2] = 32'd1000;
      bw_set[3] = $urandom;
      gaps_on = 1'b1;
      for (int ph = 0; ph < 5; ph++) begin
         if (ph < 4) set_bandwidth(bw_set[ph]);
         else gaps_on = 1'b0;
         for (int n = 0; n < 386; n++) cmd_queue.push_back(rand_cmd(55));
         wait_drained();
      end

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

>>> first_match_rate_quota.f
rtl/core/fmrq_pkg.sv
rtl/core/fmrq_cell.sv
rtl/core/fmrq_div.sv
rtl/core/first_match_rate_quota.sv
tb/tb_first_match_rate_quota.sv
